// ----- hdl/hff_pkg.sv -----
// ----------------------------------------------------------------------------
// Hex field formatter package
// Shared constants, the item descriptor, the status record and the digit character function.
// ----------------------------------------------------------------------------
package hff_pkg;

  localparam int MaxWidthDefault  = 64;
  localparam int ValueBitsDefault = 32;
  localparam int QueueDepth       = 2;

  // Field positions; wide enough for any field width or precision.
  localparam int CW = 8;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;

  // Segment ends of one field, counted in characters from its start.
  typedef struct packed {
    logic [CW-1:0] lead_end;
    logic [CW-1:0] prefix_end;
    logic [CW-1:0] zeros_end;
    logic [CW-1:0] digits_end;
    logic [CW-1:0] total;
    logic          upper;
  } hff_desc_t;

  typedef struct packed {
    logic          active;
    logic [CW-1:0] pos;
    logic [CW-1:0] total;
  } hff_status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'h0, nib};
    end else if (upper) begin
      ch = 8'h37 + {4'h0, nib};
    end else begin
      ch = 8'h57 + {4'h0, nib};
    end
    return ch;
  endfunction

endpackage

// ----- hdl/hff_front.sv -----
// ----------------------------------------------------------------------------
// Hex field formatter front end
// Accepts a word, counts its digits and works out where each segment of the
// formatted field ends.
// ----------------------------------------------------------------------------
module hff_front #(
  parameter int MAX_WIDTH  = hff_pkg::MaxWidthDefault,
  parameter int VALUE_BITS = hff_pkg::ValueBitsDefault,
  parameter int VP         = 4 * ((VALUE_BITS + 3) / 4)
) (
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_BITS-1:0]  value_i,
  input  logic [6:0]             field_width_i,
  input  logic signed [6:0]      precision_i,
  input  logic                   has_precision_i,
  input  logic                   alternate_i,
  input  logic                   left_justify_i,
  input  logic                   zero_pad_i,
  input  logic                   upper_case_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output hff_pkg::hff_desc_t     q_desc_o,
  output logic [VP-1:0]          q_value_o
);
  import hff_pkg::*;

  localparam int Nibbles = VP / 4;
  localparam int LW      = $clog2(Nibbles + 1);

  logic [VP-1:0] vpad;
  logic          nonzero;
  logic [LW-1:0] msn;
  logic [LW-1:0] len_n;
  logic [LW-1:0] shift_n;
  logic          prec_on;
  logic          zero_fill;
  logic [CW-1:0] prec_u;
  logic [CW-1:0] len_c;
  logic [CW-1:0] zprec;
  logic [CW-1:0] pfx;
  logic [CW-1:0] body;
  logic [CW-1:0] width_c;
  logic [CW-1:0] pad;
  logic [CW-1:0] lead;
  logic [CW-1:0] zeros;
  logic [CW-1:0] trail;
  logic [CW-1:0] b1;
  logic [CW-1:0] b2;
  logic [CW-1:0] b3;
  logic [CW-1:0] b4;
  logic [CW-1:0] b5;

  assign vpad    = VP'(value_i);
  assign nonzero = |vpad;

  always_comb begin
    msn = '0;
    for (int i = 0; i < Nibbles; i++) begin
      if (vpad[4*i +: 4] != 4'h0) begin
        msn = LW'(i + 1);
      end
    end
  end

  assign prec_on = has_precision_i && !precision_i[6];
  assign prec_u  = CW'(precision_i[5:0]);

  always_comb begin
    if (!nonzero && prec_on && (prec_u == '0)) begin
      len_n = '0;
    end else if (!nonzero) begin
      len_n = LW'(1);
    end else begin
      len_n = msn;
    end
  end

  assign len_c     = CW'(len_n);
  assign zprec     = (prec_on && (prec_u > len_c)) ? (prec_u - len_c) : '0;
  assign pfx       = (alternate_i && nonzero) ? CW'(2) : '0;
  assign body      = zprec + len_c + pfx;
  assign width_c   = CW'(field_width_i);
  assign pad       = (width_c > body) ? (width_c - body) : '0;
  assign zero_fill = zero_pad_i && !left_justify_i && !prec_on;

  assign lead  = (!left_justify_i && !zero_fill) ? pad : '0;
  assign zeros = zero_fill ? pad : zprec;
  assign trail = left_justify_i ? pad : '0;

  assign b1 = lead;
  assign b2 = b1 + pfx;
  assign b3 = b2 + zeros;
  assign b4 = b3 + len_c;
  assign b5 = b4 + trail;

  // Left-align the value so that its first digit sits in the top nibble.
  assign shift_n   = LW'(Nibbles) - len_n;
  assign q_value_o = vpad << {shift_n, 2'b00};

  always_comb begin
    q_desc_o.lead_end   = b1;
    q_desc_o.prefix_end = b2;
    q_desc_o.zeros_end  = b3;
    q_desc_o.digits_end = b4;
    q_desc_o.total      = (b5 > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : b5;
    q_desc_o.upper      = upper_case_i;
  end

  // An empty field is taken and dropped.
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && (q_desc_o.total != '0);

endmodule

// ----- hdl/hff_fifo.sv -----
// ----------------------------------------------------------------------------
// Hex field formatter queue
// Short first-in first-out buffer between the front and the back end.
// ----------------------------------------------------------------------------
module hff_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hff_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           push_data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic                       valid_o,
  output logic [WIDTH-1:0]           pop_data_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  import hff_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o     = (count_q == NW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign count_o    = count_q;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + NW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/hff_back.sv -----
// ----------------------------------------------------------------------------
// Hex field formatter back end
// Walks one field a character at a time and drives the output register.
// ----------------------------------------------------------------------------
module hff_back #(
  parameter int VP = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  hff_pkg::hff_desc_t   q_desc_i,
  input  logic [VP-1:0]        q_value_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_char_o,
  output logic                 last_char_o,
  output hff_pkg::hff_status_t status_o
);
  import hff_pkg::*;

  logic          active_q, active_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          out_valid_q, out_valid_d;
  hff_desc_t     desc_q;
  logic [VP-1:0] val_q;
  logic [7:0]    out_char_q;
  logic          last_q;
  logic          take;
  logic          emit;
  logic          is_last;
  logic          in_digits;
  logic [7:0]    ch;

  assign take    = !active_q && q_valid_i;
  assign emit    = active_q && (!out_valid_q || !out_stall_i);
  assign q_pop_o = take;
  assign is_last = (pos_q == desc_q.total - CW'(1));

  always_comb begin
    in_digits = 1'b0;
    if (pos_q < desc_q.lead_end) begin
      ch = ChSpace;
    end else if (pos_q < desc_q.prefix_end) begin
      if (pos_q == desc_q.lead_end) begin
        ch = ChZero;
      end else begin
        ch = desc_q.upper ? ChUpX : ChLowX;
      end
    end else if (pos_q < desc_q.zeros_end) begin
      ch = ChZero;
    end else if (pos_q < desc_q.digits_end) begin
      in_digits = 1'b1;
      ch        = hex_char(val_q[VP-1 -: 4], desc_q.upper);
    end else begin
      ch = ChSpace;
    end
  end

  always_comb begin
    active_d    = active_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (take) begin
      active_d = 1'b1;
      pos_d    = '0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      pos_d       = pos_q + CW'(1);
      if (is_last) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      desc_q <= q_desc_i;
      val_q  <= q_value_i;
    end else if (emit && in_digits) begin
      val_q <= val_q << 4;
    end
    if (emit) begin
      out_char_q <= ch;
      last_q     <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = last_q;

  always_comb begin
    status_o.active = active_q;
    status_o.pos    = pos_q;
    status_o.total  = desc_q.total;
  end

endmodule

// ----- hdl/hex_field_formatter.sv -----
// ----------------------------------------------------------------------------
// Hex field formatter
// Formats an unsigned value as printf-style %x / %X text, one character per
// output word, with the last character of each field marked.
// ----------------------------------------------------------------------------
//  Channel  Handshake               Payload
//  in       in_valid_i / in_stall_o  value_i, field_width_i, precision_i,
//                                   has_precision_i, alternate_i,
//                                   left_justify_i, zero_pad_i, upper_case_i
//  out      out_valid_o / out_stall_i out_char_o, last_char_o
//
//  A field of N characters (N up to MAX_WIDTH) is first loaded into the back
//  end, then leaves one character per cycle from its position counter while the
//  output is not stalled. An empty field is taken and gives no output word.
//  A two-entry queue lets the front take new words while the back is busy.
//  Reset clears the queue and the back end; no output is pending after it.
//  Output stalls hold the output register and stop the character walk.
// ----------------------------------------------------------------------------
module hex_field_formatter #(
  parameter int MAX_WIDTH  = hff_pkg::MaxWidthDefault,
  parameter int VALUE_BITS = hff_pkg::ValueBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [6:0]            field_width_i,
  input  logic signed [6:0]     precision_i,
  input  logic                  has_precision_i,
  input  logic                  alternate_i,
  input  logic                  left_justify_i,
  input  logic                  zero_pad_i,
  input  logic                  upper_case_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_char_o,
  output logic                  last_char_o
);
  import hff_pkg::*;

  localparam int VP = 4 * ((VALUE_BITS + 3) / 4);
  localparam int DW = $bits(hff_desc_t);
  localparam int QW = VP + DW;
  localparam int NW = $clog2(QueueDepth + 1);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  hff_desc_t     push_desc;
  logic [VP-1:0] push_value;
  logic [QW-1:0] pop_word;
  logic [NW-1:0] q_count;
  hff_status_t   status;

  hff_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .VALUE_BITS(VALUE_BITS),
    .VP        (VP)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .value_i        (value_i),
    .field_width_i  (field_width_i),
    .precision_i    (precision_i),
    .has_precision_i(has_precision_i),
    .alternate_i    (alternate_i),
    .left_justify_i (left_justify_i),
    .zero_pad_i     (zero_pad_i),
    .upper_case_i   (upper_case_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_desc_o       (push_desc),
    .q_value_o      (push_value)
  );

  hff_fifo #(
    .WIDTH(QW),
    .DEPTH(QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i({push_value, push_desc}),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (pop_word),
    .count_o    (q_count)
  );

  hff_back #(
    .VP(VP)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_desc_i   (pop_word[DW-1:0]),
    .q_value_i  (pop_word[QW-1:DW]),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_char_o (out_char_o),
    .last_char_o(last_char_o),
    .status_o   (status)
  );

  // The character walk never runs past the end of its field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.active |-> (status.pos < status.total))
    else $error("character position beyond field end");

  // The queue never holds more words than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= NW'(QueueDepth))
    else $error("queue count exceeds depth");

  // While a character that is not the last is taken, its field is still open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_char_o) |-> status.active)
    else $error("field closed before its last character");

  // A field that has just been loaded is never empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(status.active) |-> (status.total != '0))
    else $error("empty field loaded into back end");

endmodule
